>>> rtl/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and constants for the source text tokenizer.
// ----------------------------------------------------------------------------
package stc_pkg;

    // Default widths of the internal offset and length counters
    localparam int OFFSET_BITS_DEF = 32;
    localparam int LENGTH_BITS_DEF = 16;

    // Fixed widths of the result word fields
    localparam int KIND_W   = 4;
    localparam int OUT_OFS_W = 32;
    localparam int OUT_LEN_W = 16;

    // Result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    // Token kinds
    localparam logic [KIND_W-1:0] K_EOF    = 4'd0;
    localparam logic [KIND_W-1:0] K_NUM    = 4'd1;
    localparam logic [KIND_W-1:0] K_IDENT  = 4'd2;
    localparam logic [KIND_W-1:0] K_FN     = 4'd3;
    localparam logic [KIND_W-1:0] K_LET    = 4'd4;
    localparam logic [KIND_W-1:0] K_RETURN = 4'd5;
    localparam logic [KIND_W-1:0] K_EQUAL  = 4'd6;
    localparam logic [KIND_W-1:0] K_ADD    = 4'd7;
    localparam logic [KIND_W-1:0] K_SEMI   = 4'd8;
    localparam logic [KIND_W-1:0] K_COMMA  = 4'd9;
    localparam logic [KIND_W-1:0] K_LPAREN = 4'd10;
    localparam logic [KIND_W-1:0] K_RPAREN = 4'd11;
    localparam logic [KIND_W-1:0] K_LBRACE = 4'd12;
    localparam logic [KIND_W-1:0] K_RBRACE = 4'd13;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [OUT_OFS_W-1:0] start;
        logic [OUT_LEN_W-1:0] tlen;
        logic                 last;
    } token_t;

    // Tokens produced by one accepted byte
    typedef struct packed {
        logic [1:0] n;
        token_t     t0;
        token_t     t1;
    } push_t;

endpackage

>>> rtl/stc_lexer.sv
// ----------------------------------------------------------------------------
// stc_lexer
// Scanner state and per-byte token logic: up to two tokens per byte.
// ----------------------------------------------------------------------------
module stc_lexer #(
    parameter int OFFSET_BITS = stc_pkg::OFFSET_BITS_DEF,
    parameter int LENGTH_BITS = stc_pkg::LENGTH_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          ch,
    output stc_pkg::push_t      push
);

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_NUM   = 3'b010,
        MODE_IDENT = 3'b100
    } mode_t;

    typedef enum logic [1:0] {
        KW_NONE   = 2'd0,
        KW_FN     = 2'd1,
        KW_LET    = 2'd2,
        KW_RETURN = 2'd3
    } kw_t;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
    localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return ((c >= 8'h09) && (c <= 8'h0D)) || (c == 8'h20);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c >= 8'h21) && (c <= 8'h7E) && !is_digit(c) && !is_alpha(c);
    endfunction

    function automatic logic [stc_pkg::KIND_W-1:0] single_kind(input logic [7:0] c);
        logic [stc_pkg::KIND_W-1:0] k;
        case (c)
            8'h3D:   k = stc_pkg::K_EQUAL;
            8'h2B:   k = stc_pkg::K_ADD;
            8'h3B:   k = stc_pkg::K_SEMI;
            8'h2C:   k = stc_pkg::K_COMMA;
            8'h28:   k = stc_pkg::K_LPAREN;
            8'h29:   k = stc_pkg::K_RPAREN;
            8'h7B:   k = stc_pkg::K_LBRACE;
            8'h7D:   k = stc_pkg::K_RBRACE;
            default: k = stc_pkg::K_EOF;
        endcase
        return k;
    endfunction

    function automatic logic [2:0] kw_len(input kw_t k);
        logic [2:0] l;
        case (k)
            KW_FN:     l = 3'd2;
            KW_LET:    l = 3'd3;
            KW_RETURN: l = 3'd6;
            default:   l = 3'd0;
        endcase
        return l;
    endfunction

    // Expected byte at position idx; the first byte is matched on opening
    function automatic logic [7:0] kw_char(input kw_t k, input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            KW_FN:
                if (idx == 3'd1) c = "n";
            KW_LET:
                case (idx)
                    3'd1:    c = "e";
                    3'd2:    c = "t";
                    default: c = 8'h00;
                endcase
            KW_RETURN:
                case (idx)
                    3'd1:    c = "e";
                    3'd2:    c = "t";
                    3'd3:    c = "u";
                    3'd4:    c = "r";
                    3'd5:    c = "n";
                    default: c = 8'h00;
                endcase
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    mode_t                  mode_reg,   mode_next;
    logic [OFFSET_BITS-1:0] start_reg,  start_next;
    logic [LENGTH_BITS-1:0] tlen_reg,   tlen_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    kw_t                    cand_reg,   cand_next;
    logic                   match_reg,  match_next;

    logic                   open_tok;
    logic                   cont;
    logic                   close_tok;
    logic                   own_tok;
    logic [stc_pkg::KIND_W-1:0] close_kind;
    logic [stc_pkg::KIND_W-1:0] own_kind;
    logic [stc_pkg::KIND_W-1:0] sk;
    logic [OFFSET_BITS-1:0] own_start;
    logic [OFFSET_BITS-1:0] offset_inc;
    logic                   len_short;
    stc_pkg::token_t        close_word;
    stc_pkg::token_t        own_word;

    assign offset_inc = offset_reg + OFFSET_BITS'(1);
    assign sk         = single_kind(ch);
    assign open_tok   = (mode_reg == MODE_NUM) || (mode_reg == MODE_IDENT);
    assign len_short  = tlen_reg < LENGTH_BITS'(kw_len(cand_reg));

    always_comb
    begin
        case (mode_reg)
            MODE_NUM:   cont = is_digit(ch);
            MODE_IDENT: cont = (ch != 8'h00) && !is_space(ch) && !is_punct(ch);
            default:    cont = 1'b0;
        endcase
    end

    always_comb
    begin
        if ((mode_reg == MODE_IDENT) && match_reg && (cand_reg != KW_NONE)
            && (tlen_reg == LENGTH_BITS'(kw_len(cand_reg))))
            close_kind = stc_pkg::K_FN + stc_pkg::KIND_W'(cand_reg) - stc_pkg::KIND_W'(1);
        else if (mode_reg == MODE_IDENT)
            close_kind = stc_pkg::K_IDENT;
        else
            close_kind = stc_pkg::K_NUM;
    end

    always_comb
    begin
        mode_next   = mode_reg;
        start_next  = start_reg;
        tlen_next   = tlen_reg;
        offset_next = offset_reg;
        cand_next   = cand_reg;
        match_next  = match_reg;
        close_tok   = 1'b0;
        own_tok     = 1'b0;
        own_kind    = stc_pkg::K_EOF;
        own_start   = offset_reg;

        if (open_tok && cont)
        begin
            // Extend the open token
            if (match_reg && (!len_short || (kw_char(cand_reg, tlen_reg[2:0]) != ch)))
                match_next = 1'b0;
            if (tlen_reg != LEN_MAX)
                tlen_next = tlen_reg + LEN_ONE;
            offset_next = offset_inc;
        end
        else
        begin
            close_tok  = open_tok;
            mode_next  = MODE_IDLE;
            cand_next  = KW_NONE;
            match_next = 1'b0;

            if (ch == 8'h00)
            begin
                own_tok     = 1'b1;
                own_kind    = stc_pkg::K_EOF;
                offset_next = '0;
            end
            else if ((ch == 8'h20) || (ch == 8'h0D) || (ch == 8'h09) || (ch == 8'h0A))
            begin
                offset_next = offset_inc;
            end
            else if (sk != stc_pkg::K_EOF)
            begin
                own_tok     = 1'b1;
                own_kind    = sk;
                offset_next = offset_inc;
            end
            else if (is_digit(ch))
            begin
                mode_next   = MODE_NUM;
                start_next  = offset_reg;
                tlen_next   = LEN_ONE;
                offset_next = offset_inc;
            end
            else
            begin
                mode_next   = MODE_IDENT;
                start_next  = offset_reg;
                tlen_next   = LEN_ONE;
                offset_next = offset_inc;
                case (ch)
                    "f":     cand_next = KW_FN;
                    "l":     cand_next = KW_LET;
                    "r":     cand_next = KW_RETURN;
                    default: cand_next = KW_NONE;
                endcase
                match_next  = (cand_next != KW_NONE);
            end
        end
    end

    always_comb
    begin
        close_word.kind  = close_kind;
        close_word.start = stc_pkg::OUT_OFS_W'(start_reg);
        close_word.tlen  = stc_pkg::OUT_LEN_W'(tlen_reg);
        close_word.last  = !own_tok;
        own_word.kind    = own_kind;
        own_word.start   = stc_pkg::OUT_OFS_W'(own_start);
        own_word.tlen    = stc_pkg::OUT_LEN_W'(1);
        own_word.last    = 1'b1;

        push.n  = step ? (2'(close_tok) + 2'(own_tok)) : 2'd0;
        push.t0 = close_tok ? close_word : own_word;
        push.t1 = own_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            start_reg  <= '0;
            tlen_reg   <= '0;
            offset_reg <= '0;
            cand_reg   <= KW_NONE;
            match_reg  <= 1'b0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            start_reg  <= start_next;
            tlen_reg   <= tlen_next;
            offset_reg <= offset_next;
            cand_reg   <= cand_next;
            match_reg  <= match_next;
        end
    end

    a_eof_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (ch == 8'h00)) |=> ((mode_reg == MODE_IDLE) && (offset_reg == '0)))
        else $error("end of text did not restart the scanner");

    a_match_needs_ident: assert property (@(posedge clk) disable iff (!rst_n)
        match_reg |-> ((mode_reg == MODE_IDENT) && (cand_reg != KW_NONE)))
        else $error("keyword match held outside an identifier");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n == 2'd2) |-> (!push.t0.last && push.t1.last))
        else $error("two tokens pushed with wrong last marks");

endmodule

>>> rtl/stc_out_fifo.sv
// ----------------------------------------------------------------------------
// stc_out_fifo
// Small result queue: takes up to two words per cycle; pops one on out_ready.
// ----------------------------------------------------------------------------
module stc_out_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  stc_pkg::push_t        push,
    output logic                  room,
    output logic                  out_valid,
    input  logic                  out_ready,
    output stc_pkg::token_t       head
);

    stc_pkg::token_t             mem [stc_pkg::Q_DEPTH];
    logic [stc_pkg::Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [stc_pkg::Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [stc_pkg::Q_CNT_W-1:0] count_reg,  count_next;
    logic [stc_pkg::Q_PTR_W-1:0] wr_ptr_inc;
    logic                        pop;

    assign out_valid   = (count_reg != '0);
    assign pop         = out_valid && out_ready;
    assign head        = mem[rd_ptr_reg];
    // Keep space for the worst case of two words from the next byte
    assign room        = count_reg <= stc_pkg::Q_CNT_W'(stc_pkg::Q_DEPTH - 2);
    assign wr_ptr_inc  = wr_ptr_reg + stc_pkg::Q_PTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + stc_pkg::Q_PTR_W'(push.n);
    assign rd_ptr_next = rd_ptr_reg + stc_pkg::Q_PTR_W'(pop);
    assign count_next  = count_reg + stc_pkg::Q_CNT_W'(push.n) - stc_pkg::Q_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            mem[wr_ptr_reg] <= push.t0;
        if (push.n == 2'd2)
            mem[wr_ptr_inc] <= push.t1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0) |-> (count_reg <= stc_pkg::Q_CNT_W'(stc_pkg::Q_DEPTH - 2)))
        else $error("word pushed into a full result queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= stc_pkg::Q_CNT_W'(stc_pkg::Q_DEPTH))
        else $error("result queue count out of range");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (push.n == 2'd0)) |=> (count_reg == $past(count_reg) - stc_pkg::Q_CNT_W'(1)))
        else $error("queue count wrong after a lone pop");

endmodule

>>> rtl/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming tokenizer: one text byte in, tokens (kind, offset, length) out.
// ----------------------------------------------------------------------------
//  channel | signals                                     | handshake
//  --------+---------------------------------------------+--------------------
//  input   | ch                                          | in_valid/in_ready
//  output  | kind, start_offset, token_len, last_of_run  | out_valid/out_ready
//
//  One byte is taken per cycle while in_ready is high; the scanner state
//  updates and its tokens enter the result queue at the accepting edge.
//  A byte yields zero, one or two tokens; the output gives one per cycle while
//  out_ready is high. in_ready falls while the four-word queue holds more
//  than two words. Reset leaves the scanner idle at offset zero, queue empty.
// ----------------------------------------------------------------------------
module source_text_tokenizer #(
    parameter int OFFSET_BITS = stc_pkg::OFFSET_BITS_DEF,
    parameter int LENGTH_BITS = stc_pkg::LENGTH_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      ch,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [stc_pkg::KIND_W-1:0]      kind,
    output logic [stc_pkg::OUT_OFS_W-1:0]   start_offset,
    output logic [stc_pkg::OUT_LEN_W-1:0]   token_len,
    output logic                            last_of_run
);

    stc_pkg::push_t  push;
    stc_pkg::token_t head;
    logic            step;

    assign step = in_valid && in_ready;

    stc_lexer #(
        .OFFSET_BITS (OFFSET_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_lexer (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .ch    (ch),
        .push  (push)
    );

    stc_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign kind         = head.kind;
    assign start_offset = head.start;
    assign token_len    = head.tlen;
    assign last_of_run  = head.last;

endmodule

>>> tb/tokenizer_checker.sv
// ----------------------------------------------------------------------------
// tokenizer_checker
// Watches both channels of the tokenizer. Each accepted byte runs through a
// scanner model that queues the tokens it yields, and every token word taken
// at the output is compared field by field with the oldest queued token.
// ----------------------------------------------------------------------------
module tokenizer_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [7:0]                    ch,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [stc_pkg::KIND_W-1:0]    kind,
    input  logic [stc_pkg::OUT_OFS_W-1:0] start_offset,
    input  logic [stc_pkg::OUT_LEN_W-1:0] token_len,
    input  logic                          last_of_run,
    output int                            errors,
    output int                            outstanding
);

    localparam int                            MAX_REPORTS = 40;
    localparam logic [stc_pkg::OUT_LEN_W-1:0] LEN_SAT     = '1;

    localparam logic [7:0] NUL   = 8'h00;
    localparam logic [7:0] TAB   = 8'h09;
    localparam logic [7:0] LF    = 8'h0A;
    localparam logic [7:0] CR    = 8'h0D;
    localparam logic [7:0] SPACE = 8'h20;

    typedef enum logic [2:0] {
        SCAN_IDLE  = 3'b001,
        SCAN_NUM   = 3'b010,
        SCAN_IDENT = 3'b100
    } scan_t;

    typedef enum logic [1:0] {
        KW_NONE   = 2'd0,
        KW_FN     = 2'd1,
        KW_LET    = 2'd2,
        KW_RETURN = 2'd3
    } kw_t;

    scan_t                         scan_state  = SCAN_IDLE;
    logic [stc_pkg::OUT_OFS_W-1:0] tok_start   = '0;
    logic [stc_pkg::OUT_LEN_W-1:0] tok_len     = '0;
    logic [stc_pkg::OUT_OFS_W-1:0] text_pos    = '0;
    kw_t                           kw_guess    = KW_NONE;
    logic                          kw_alive    = 1'b0;
    stc_pkg::token_t               due_tokens [$];
    int                            tokens_seen = 0;

    initial
    begin
        errors      = 0;
        outstanding = 0;
    end

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c >= TAB && c <= CR) || c == SPACE;
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c >= 8'h21 && c <= 8'h7E && !is_digit(c) && !is_letter(c);
    endfunction

    function automatic logic word_char(input logic [7:0] c);
        return c != NUL && !is_blank(c) && !is_punct(c);
    endfunction

    // K_EOF stands for "no one-byte token" here
    function automatic logic [stc_pkg::KIND_W-1:0] punct_kind(input logic [7:0] c);
        case (c)
            "=":     return stc_pkg::K_EQUAL;
            "+":     return stc_pkg::K_ADD;
            ";":     return stc_pkg::K_SEMI;
            ",":     return stc_pkg::K_COMMA;
            "(":     return stc_pkg::K_LPAREN;
            ")":     return stc_pkg::K_RPAREN;
            "{":     return stc_pkg::K_LBRACE;
            "}":     return stc_pkg::K_RBRACE;
            default: return stc_pkg::K_EOF;
        endcase
    endfunction

    function automatic string kw_spelling(input kw_t k);
        case (k)
            KW_FN:     return "fn";
            KW_LET:    return "let";
            KW_RETURN: return "return";
            default:   return "";
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        if (errors < MAX_REPORTS)
            $display("%0t tokenizer mismatch: %s", $time, what);
        errors++;
    endtask

    task automatic lex_byte(input logic [7:0] c);
        stc_pkg::token_t            first;
        stc_pkg::token_t            second;
        stc_pkg::token_t            made;
        int                         n;
        logic                       absorbed;
        logic                       yields;
        logic [stc_pkg::KIND_W-1:0] single;
        string                      word;
        n        = 0;
        absorbed = 1'b0;
        yields   = 1'b0;
        word     = kw_spelling(kw_guess);
        if (scan_state == SCAN_NUM || scan_state == SCAN_IDENT)
        begin
            if (scan_state == SCAN_NUM ? is_digit(c) : word_char(c))
            begin
                // drop the keyword match once the byte leaves its spelling
                if (kw_alive && (tok_len >= word.len() || word[tok_len] != c))
                    kw_alive = 1'b0;
                if (tok_len != LEN_SAT)
                    tok_len++;
                text_pos++;
                absorbed = 1'b1;
            end
            else
            begin
                first.kind = stc_pkg::K_NUM;
                if (scan_state == SCAN_IDENT)
                begin
                    first.kind = stc_pkg::K_IDENT;
                    if (kw_alive && tok_len == word.len())
                    begin
                        case (kw_guess)
                            KW_FN:     first.kind = stc_pkg::K_FN;
                            KW_LET:    first.kind = stc_pkg::K_LET;
                            KW_RETURN: first.kind = stc_pkg::K_RETURN;
                            default:   first.kind = stc_pkg::K_IDENT;
                        endcase
                    end
                end
                first.start = tok_start;
                first.tlen  = tok_len;
                first.last  = 1'b0;
                n           = 1;
                scan_state  = SCAN_IDLE;
                kw_guess    = KW_NONE;
                kw_alive    = 1'b0;
            end
        end

        if (!absorbed)
        begin
            single     = punct_kind(c);
            made.kind  = single;
            made.start = text_pos;
            made.tlen  = stc_pkg::OUT_LEN_W'(1);
            made.last  = 1'b0;
            if (c == NUL)
            begin
                made.kind = stc_pkg::K_EOF;
                yields    = 1'b1;
                text_pos  = '0;
            end
            else if (c == SPACE || c == CR || c == TAB || c == LF)
                text_pos++;
            else if (single != stc_pkg::K_EOF)
            begin
                yields = 1'b1;
                text_pos++;
            end
            else
            begin
                tok_start = text_pos;
                tok_len   = stc_pkg::OUT_LEN_W'(1);
                text_pos++;
                if (is_digit(c))
                    scan_state = SCAN_NUM;
                else
                begin
                    scan_state = SCAN_IDENT;
                    case (c)
                        "f":     kw_guess = KW_FN;
                        "l":     kw_guess = KW_LET;
                        "r":     kw_guess = KW_RETURN;
                        default: kw_guess = KW_NONE;
                    endcase
                    kw_alive = kw_guess != KW_NONE;
                end
            end
            if (yields)
            begin
                if (n == 0)
                    first = made;
                else
                    second = made;
                n++;
            end
        end

        if (n == 1)
        begin
            first.last = 1'b1;
            due_tokens.push_back(first);
        end
        else if (n == 2)
        begin
            second.last = 1'b1;
            due_tokens.push_back(first);
            due_tokens.push_back(second);
        end
    endtask

    task automatic check_token();
        stc_pkg::token_t want;
        tokens_seen++;
        if (due_tokens.size() == 0)
            report_mismatch($sformatf("token %0d with none due: kind %0d start %0d len %0d",
                                      tokens_seen, kind, start_offset, token_len));
        else
        begin
            want = due_tokens.pop_front();
            if (kind !== want.kind || start_offset !== want.start ||
                token_len !== want.tlen || last_of_run !== want.last)
                report_mismatch($sformatf(
                    "token %0d: got kind %0d start %0d len %0d last %0b, want %0d %0d %0d %0b",
                    tokens_seen, kind, start_offset, token_len, last_of_run,
                    want.kind, want.start, want.tlen, want.last));
        end
    endtask

    // check the departing word before the arriving byte adds to the queue
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_token();
            if (in_valid && in_ready)
                lex_byte(ch);
            outstanding = due_tokens.size();
        end
    end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the source text tokenizer: directed texts covering
// every token kind, keywords, odd bytes and a long token, then random
// texts under several idling patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int RANDOM_ITEMS  = 300;
    localparam int PRESSURE_HOLD = 300;
    localparam int LONG_RUN      = 40;

    localparam logic [7:0] NUL   = 8'h00;
    localparam logic [7:0] TAB   = 8'h09;
    localparam logic [7:0] LF    = 8'h0A;
    localparam logic [7:0] CR    = 8'h0D;
    localparam logic [7:0] SPACE = 8'h20;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic [7:0]                    ch        = 8'h00;
    logic                          out_ready = 1'b0;
    logic                          in_ready;
    logic                          out_valid;
    logic [stc_pkg::KIND_W-1:0]    kind;
    logic [stc_pkg::OUT_OFS_W-1:0] start_offset;
    logic [stc_pkg::OUT_LEN_W-1:0] token_len;
    logic                          last_of_run;

    int   errors;
    int   outstanding;
    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    logic rx_hold      = 1'b0;
    int   cycle_count  = 0;
    int   bytes_counted = 0;

    string letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
    string alnum   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
    string digits  = "0123456789";
    string singles = "=+;,(){}";
    string others  = "-*!#.<>/:?@[]^_`|~&%$'\"\\";
    string blanks  = " \t\r\n";

    source_text_tokenizer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .ch           (ch),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .start_offset (start_offset),
        .token_len    (token_len),
        .last_of_run  (last_of_run)
    );

    tokenizer_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .ch           (ch),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .start_offset (start_offset),
        .token_len    (token_len),
        .last_of_run  (last_of_run),
        .errors       (errors),
        .outstanding  (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[source_text_tokenizer] ERROR");
            $finish;
        end
    end

    always @(negedge clk)
        out_ready <= rst_n && !rx_hold && ($urandom_range(99) >= rx_stall_pct);

    function automatic logic [7:0] pick(input string pool);
        return pool[$urandom_range(pool.len() - 1)];
    endfunction

    function automatic logic [7:0] pick_word_char();
        if ($urandom_range(9) < 7)
            return pick(alnum);
        return 8'($urandom_range(128, 255));
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] c);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        ch       <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        if (c != SPACE && c != TAB && c != CR && c != LF)
            bytes_counted++;
    endtask

    task automatic send_word(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic set_phase(input int tx_pct, input int rx_pct);
        in_valid <= 1'b0;
        @(posedge clk);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        @(negedge clk);
    endtask

    task automatic send_piece();
        int len;
        len = $urandom_range(0, 6);
        case ($urandom_range(9))
            0:
                case ($urandom_range(2))
                    0:       send_word("fn");
                    1:       send_word("let");
                    default: send_word("return");
                endcase
            1:
                case ($urandom_range(7))
                    0:       send_word("f");
                    1:       send_word("fnn");
                    2:       send_word("le");
                    3:       send_word("lets");
                    4:       send_word("retur");
                    5:       send_word("returns");
                    6:       send_word("ret9");
                    default: send_word("Fn");
                endcase
            2:
            begin
                send_byte(pick(letters));
                repeat (len) send_byte(pick_word_char());
            end
            3:
                repeat (len + 1) send_byte(pick(digits));
            4, 5:
                send_byte(pick(singles));
            6:
            begin
                send_byte(pick(others));
                repeat (len) send_byte(pick_word_char());
            end
            7:
                send_byte(8'($urandom_range(1, 255)));
            8:
            begin
                case ($urandom_range(2))
                    0:       send_byte(8'h0B);
                    1:       send_byte(8'h0C);
                    default: send_byte(8'($urandom_range(128, 255)));
                endcase
                repeat (len) send_byte(pick_word_char());
            end
            default:
            begin
                // number running straight into a letter
                repeat (len + 1) send_byte(pick(digits));
                send_byte(pick(letters));
            end
        endcase
    endtask

    task automatic send_random_text();
        int pieces;
        pieces = $urandom_range(0, 10);
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(255)));
        else
            repeat (pieces)
            begin
                send_piece();
                if ($urandom_range(1))
                    send_byte(pick(blanks));
            end
        send_byte(NUL);
    endtask

    initial
    begin
        int pressure_start;
        int phase_end;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_phase(0, 0);
        send_word("fn(let,return){a9=7q+-;}");
        send_byte(NUL);
        send_word(" \t\r\n");
        send_byte(8'h0B);
        send_byte(8'h0C);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'h01);
        send_word("5 12");
        send_byte(NUL);
        // long identifier that starts like a keyword
        send_byte("r");
        repeat (LONG_RUN) send_byte("e");
        send_byte(NUL);

        bytes_counted = 0;
        phase_end     = RANDOM_ITEMS / 5;
        while (bytes_counted < phase_end)
            send_random_text();

        // hold the output so that the result queue fills and stalls the input
        pressure_start = bytes_counted;
        fork
            begin
                @(posedge clk);
                rx_hold = 1'b1;
                repeat (PRESSURE_HOLD) @(posedge clk);
                rx_hold = 1'b0;
            end
            begin
                while (bytes_counted < pressure_start + 40)
                    send_random_text();
            end
        join

        set_phase(72, 0);
        phase_end = bytes_counted + RANDOM_ITEMS / 5;
        while (bytes_counted < phase_end)
            send_random_text();

        set_phase(0, 72);
        phase_end = bytes_counted + RANDOM_ITEMS / 5;
        while (bytes_counted < phase_end)
            send_random_text();

        set_phase(15, 15);
        while (bytes_counted < RANDOM_ITEMS)
            send_random_text();

        set_phase(0, 0);
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0 && outstanding == 0)
            $display("[source_text_tokenizer] OK");
        else
            $display("[source_text_tokenizer] ERROR");
        $finish;
    end

endmodule
